>>> hdl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and constants for the multichannel moving average block.
// ----------------------------------------------------------------------------
package mma_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CHAN_W   = 3;

   typedef logic        [CHAN_W-1:0]   chan_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;

endpackage

>>> hdl/mma_req_if.sv
// ----------------------------------------------------------------------------
// mma_req_if
// Sample channel: channel number and Q16.16 sample, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mma_req_if;

   logic                 valid;
   logic                 ready;
   mma_pkg::chan_type    channel;
   mma_pkg::sample_type  sample;

   modport source (output valid, output channel, output sample, input ready);
   modport sink   (input valid, input channel, input sample, output ready);

endinterface

>>> hdl/mma_rsp_if.sv
// ----------------------------------------------------------------------------
// mma_rsp_if
// Result channel: window mean and its qualifier, valid/ready handshake.
// ----------------------------------------------------------------------------
interface mma_rsp_if;

   logic                 valid;
   logic                 ready;
   mma_pkg::sample_type  average;
   logic                 ready_res;

   modport source (output valid, output average, output ready_res, input ready);
   modport sink   (input valid, input average, input ready_res, output ready);

endinterface

>>> hdl/mma_ram.sv
// ----------------------------------------------------------------------------
// mma_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// A read and a write to the same address in one cycle return the old data.
// ----------------------------------------------------------------------------
module mma_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 96
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/multichannel_moving_average.sv
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Per-channel moving average of signed Q16.16 samples over WINDOW slots.
// ----------------------------------------------------------------------------
//
//  port     | dir | words carry                    | handshake
//  ---------+-----+--------------------------------+------------------------
//  req_bus  | in  | channel (3b), sample (Q16.16)  | valid/ready, one per word
//  rsp_bus  | out | average (Q16.16), ready_res    | valid/ready, one per word
//
//  Throughput: one word per cycle while rsp_bus.ready holds, any channel mix.
//  Pipeline from acceptance to the result word: RAM read, sum update,
//  magnitude, two multiply stages, correction.
//  Reset clears valids and per-channel state; the window RAM is
//  not swept: a per-channel wrap flag masks slots never written as zero.
//  Stalls: each stage holds only while the stage after it is full and held,
//  so bubbles are squeezed out and req_bus.ready falls only on a full pipe.
//
module multichannel_moving_average #(
   parameter int WINDOW   = 16,
   parameter int CHANNELS = 6
) (
   input  logic      clock,
   input  logic      reset,
   mma_req_if.sink   req_bus,
   mma_rsp_if.source rsp_bus
);

   // ---------------------------------------------------------------------
   // Derived sizes
   // ---------------------------------------------------------------------
   localparam int LW    = $clog2(WINDOW);           // log2 of window, rounded up
   localparam int PW    = LW;                       // write position width
   localparam int CW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH = CHANNELS * WINDOW;
   localparam int AW    = $clog2(DEPTH);
   localparam int SUM_W = mma_pkg::SAMPLE_W + LW;   // holds WINDOW * 2^31
   localparam int PRD_W = SUM_W + 33;

   // Reciprocal: floor(2^SUM_W / WINDOW) < 2^33. With magnitude below
   // 2^SUM_W the estimate is at most one short, fixed by one compare.
   localparam logic [63:0] RECIP_WIDE = (64'd1 << SUM_W) / 64'(WINDOW);
   localparam logic [32:0] RECIP      = RECIP_WIDE[32:0];

   localparam logic [PW:0]        POS_WRAP = (PW+1)'(WINDOW);
   localparam logic [PW:0]        POS_WARM = (PW+1)'(WINDOW - 2);
   localparam logic [SUM_W-1:0]   WIN_SUM  = SUM_W'(WINDOW);
   localparam logic [mma_pkg::CHAN_W:0] CHAN_LIMIT = (mma_pkg::CHAN_W+1)'(CHANNELS);

   // ---------------------------------------------------------------------
   // Per-channel state
   // ---------------------------------------------------------------------
   logic [PW-1:0]           pos_ff  [CHANNELS];
   logic [PW-1:0]           pos_in  [CHANNELS];
   logic [CHANNELS-1:0]     warm_ff, warm_in;   // warm-up finished
   logic [CHANNELS-1:0]     full_ff, full_in;   // window has wrapped once
   logic signed [SUM_W-1:0] sum_ff  [CHANNELS];
   logic signed [SUM_W-1:0] sum_in  [CHANNELS];

   // ---------------------------------------------------------------------
   // Pipeline registers
   // ---------------------------------------------------------------------
   logic                    v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, vo_ff;
   logic                    en1, en2, en3, en4, en5, en6, en_o;

   logic [CW-1:0]           ch1_ff;
   logic                    ok1_ff, full1_ff, emit1_ff;
   mma_pkg::sample_type     smp1_ff;

   logic                    emit2_ff;
   logic signed [SUM_W-1:0] sum2_ff;

   logic                    emit3_ff, neg3_ff;
   logic [SUM_W-1:0]        mag3_ff;

   logic                    emit4_ff, neg4_ff;
   logic [SUM_W-1:0]        mag4_ff;
   logic [64:0]             plo4_ff;
   logic [LW+32:0]          phi4_ff;

   logic                    emit5_ff, neg5_ff;
   logic [SUM_W-1:0]        mag5_ff;
   logic [31:0]             q05_ff;

   logic                    emit6_ff, neg6_ff;
   logic [SUM_W-1:0]        mag6_ff, qw6_ff;
   logic [31:0]             q06_ff;

   mma_pkg::sample_type     avg_ff;
   logic                    rdy_ff;

   // ---------------------------------------------------------------------
   // Stall chain: a stage moves when the next one is empty or moving
   // ---------------------------------------------------------------------
   assign en_o = !vo_ff || rsp_bus.ready;
   assign en6  = !v6_ff || en_o;
   assign en5  = !v5_ff || en6;
   assign en4  = !v4_ff || en5;
   assign en3  = !v3_ff || en4;
   assign en2  = !v2_ff || en3;
   assign en1  = !v1_ff || en2;

   assign req_bus.ready = en1;

   // ---------------------------------------------------------------------
   // Input decode and window RAM access
   // ---------------------------------------------------------------------
   logic                accept;
   logic                ch_ok;
   logic [CW-1:0]       ch_idx;
   logic [PW-1:0]       cur_pos;
   logic [PW:0]         pos_next;
   logic [AW-1:0]       slot_addr;
   logic [31:0]         ram_rd;
   logic                ram_we;

   assign accept    = req_bus.valid && req_bus.ready;
   assign ch_ok     = {1'b0, req_bus.channel} < CHAN_LIMIT;
   assign ch_idx    = req_bus.channel[CW-1:0];
   assign cur_pos   = pos_ff[ch_idx];
   assign pos_next  = {1'b0, cur_pos} + (PW+1)'(1);
   assign slot_addr = AW'(32'(ch_idx) * 32'(WINDOW) + 32'(cur_pos));
   assign ram_we    = accept && ch_ok;

   // Write and read the same slot together: the read returns the word
   // being overwritten, which leaves the running sum as the word leaves stage one.
   mma_ram #(
      .WIDTH (mma_pkg::SAMPLE_W),
      .DEPTH (DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (slot_addr),
      .wr_data (req_bus.sample),
      .rd_en   (ram_we),
      .rd_addr (slot_addr),
      .rd_data (ram_rd)
   );

   // Position, warm-up and wrap flags settle at acceptance; the next word of
   // the same channel addresses a different slot.
   always_comb begin
      pos_in  = pos_ff;
      warm_in = warm_ff;
      full_in = full_ff;
      if (ram_we) begin
         if (!warm_ff[ch_idx]) begin
            pos_in[ch_idx] = pos_next[PW-1:0];
            if (pos_next >= POS_WARM) begin
               warm_in[ch_idx] = 1'b1;
            end
         end else if (pos_next == POS_WRAP) begin
            pos_in[ch_idx]  = '0;
            full_in[ch_idx] = 1'b1;
         end else begin
            pos_in[ch_idx] = pos_next[PW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            pos_ff[i] <= '0;
         end
         warm_ff <= '0;
         full_ff <= '0;
      end else begin
         pos_ff  <= pos_in;
         warm_ff <= warm_in;
         full_ff <= full_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: running sum update (old word only counts once written)
   // ---------------------------------------------------------------------
   logic signed [31:0]       old_word;
   logic signed [SUM_W-1:0]  sum_new;

   assign old_word = full1_ff ? $signed(ram_rd) : 32'sd0;
   assign sum_new  = sum_ff[ch1_ff] + SUM_W'(smp1_ff) - SUM_W'(old_word);

   always_comb begin
      sum_in = sum_ff;
      if (v1_ff && ok1_ff && en2) begin
         sum_in[ch1_ff] = sum_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         sum_ff <= sum_in;
      end
   end

   // ---------------------------------------------------------------------
   // Datapath stages
   // ---------------------------------------------------------------------
   logic                   neg2;
   logic [SUM_W-1:0]       mag2;
   logic [PRD_W-1:0]       prod5;
   logic [SUM_W-1:0]       rem_o;
   logic [31:0]            quot_o;
   mma_pkg::sample_type    mean_o;

   assign neg2   = sum2_ff[SUM_W-1];
   assign mag2   = neg2 ? SUM_W'(-sum2_ff) : SUM_W'(sum2_ff);
   assign prod5  = PRD_W'({phi4_ff, 32'b0}) + PRD_W'(plo4_ff);
   assign rem_o  = mag6_ff - qw6_ff;
   assign quot_o = q06_ff + 32'((rem_o >= WIN_SUM) ? 1 : 0);
   assign mean_o = neg6_ff ? -$signed(quot_o) : $signed(quot_o);

   always_ff @(posedge clock) begin
      if (en1) begin
         ch1_ff   <= ch_idx;
         ok1_ff   <= ch_ok;
         full1_ff <= ch_ok && full_ff[ch_idx];
         emit1_ff <= ch_ok && warm_ff[ch_idx];
         smp1_ff  <= req_bus.sample;
      end
      if (en2) begin
         emit2_ff <= emit1_ff;
         sum2_ff  <= sum_new;
      end
      if (en3) begin
         emit3_ff <= emit2_ff;
         neg3_ff  <= neg2;
         mag3_ff  <= mag2;
      end
      if (en4) begin
         emit4_ff <= emit3_ff;
         neg4_ff  <= neg3_ff;
         mag4_ff  <= mag3_ff;
         plo4_ff  <= 65'(mag3_ff[31:0]) * 65'(RECIP);
         phi4_ff  <= (LW+33)'(mag3_ff[SUM_W-1:32]) * (LW+33)'(RECIP);
      end
      if (en5) begin
         emit5_ff <= emit4_ff;
         neg5_ff  <= neg4_ff;
         mag5_ff  <= mag4_ff;
         q05_ff   <= prod5[SUM_W+31:SUM_W];
      end
      if (en6) begin
         emit6_ff <= emit5_ff;
         neg6_ff  <= neg5_ff;
         mag6_ff  <= mag5_ff;
         q06_ff   <= q05_ff;
         qw6_ff   <= SUM_W'(q05_ff) * WIN_SUM;
      end
      if (en_o) begin
         avg_ff <= emit6_ff ? mean_o : '0;
         rdy_ff <= emit6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (en1)  v1_ff <= req_bus.valid;
         if (en2)  v2_ff <= v1_ff;
         if (en3)  v3_ff <= v2_ff;
         if (en4)  v4_ff <= v3_ff;
         if (en5)  v5_ff <= v4_ff;
         if (en6)  v6_ff <= v5_ff;
         if (en_o) vo_ff <= v6_ff;
      end
   end

   assign rsp_bus.valid     = vo_ff;
   assign rsp_bus.average   = avg_ff;
   assign rsp_bus.ready_res = rdy_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_zero_when_not_ready : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.ready_res |-> rsp_bus.average == '0)
      else $error("average not zero on a warm-up or rejected word");

   a_wrap_after_warm : assert property (@(posedge clock) disable iff (reset)
      ram_we && full_ff[ch_idx] |-> warm_ff[ch_idx])
      else $error("window wrapped before warm-up ended");

   a_pos_in_window : assert property (@(posedge clock) disable iff (reset)
      ram_we |-> {1'b0, cur_pos} < POS_WRAP)
      else $error("write position beyond window");

   a_sum_once : assert property (@(posedge clock) disable iff (reset)
      v1_ff && !en2 |=> v1_ff && $stable(sum2_ff))
      else $error("stage one left or sum moved while held");

endmodule
